[rtl/lldptlv_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the LLDP TLV stream parser.
// Used by lldptlv_parse, lldptlv_outq and lldp_tlv_stream_parser.
package lldptlv_pkg;

  localparam logic [15:0] LLDP_ETHERTYPE = 16'h88cc;
  localparam logic [8:0]  LEN_MASK       = 9'h1ff;
  localparam int          OUTQ_DEPTH     = 4;

  // Parse phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_HDR_HI     = 3'd1;
  localparam logic [2:0] PH_HDR_LO     = 3'd2;
  localparam logic [2:0] PH_BODY_FIRST = 3'd3;
  localparam logic [2:0] PH_BODY       = 3'd4;
  localparam logic [2:0] PH_DONE       = 3'd5;

  // TLV types
  localparam logic [6:0] TLV_END       = 7'd0;
  localparam logic [6:0] TLV_CHASSIS   = 7'd1;
  localparam logic [6:0] TLV_PORT      = 7'd2;
  localparam logic [6:0] TLV_TTL       = 7'd3;
  localparam logic [6:0] TLV_PORT_DESC = 7'd4;
  localparam logic [6:0] TLV_SYS_NAME  = 7'd5;
  localparam logic [6:0] TLV_SYS_DESC  = 7'd6;
  localparam logic [6:0] TLV_CAPS      = 7'd7;

  // Result kinds
  localparam logic [1:0] KIND_STRING  = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Field tags
  localparam logic [2:0] TAG_CHASSIS   = 3'd0;
  localparam logic [2:0] TAG_PORT      = 3'd1;

  // Summary status
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ETHERTYPE  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED  = 3'd2;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
  localparam logic [2:0] ST_NO_CHASSIS = 3'd4;
  localparam logic [2:0] ST_NO_PORT    = 3'd5;
  localparam logic [2:0] ST_NO_TTL     = 3'd6;

  // Seen-flag bits
  localparam int FLAG_CHASSIS = 0;
  localparam int FLAG_PORT    = 1;
  localparam int FLAG_TTL     = 2;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  field_tag;
    logic        string_start;
    logic [7:0]  value_byte;
    logic        last_of_run;
    logic [2:0]  status;
    logic [15:0] ttl_seconds;
    logic [15:0] capabilities;
    logic [15:0] enabled_capabilities;
    logic [15:0] echo_port;
    logic [11:0] echo_vlan;
    logic [47:0] echo_mac;
  } res_t;

  // Up to two results produced by one accepted word
  typedef struct packed {
    logic valid0;
    logic valid1;
    res_t res0;
    res_t res1;
  } push_t;

  function automatic logic [2:0] tag_of(input logic [6:0] kind);
    logic [6:0] t;
    t = kind - 7'd2;
    case (kind)
      TLV_CHASSIS: tag_of = TAG_CHASSIS;
      TLV_PORT:    tag_of = TAG_PORT;
      default:     tag_of = t[2:0];
    endcase
  endfunction

endpackage

[rtl/lldptlv_parse.sv]
`timescale 1ns / 1ps
// Per-word TLV parse step: parser state registers and the results one word causes.
// Depends on lldptlv_pkg.
module lldptlv_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  input  logic [15:0]          ethertype,
  input  logic [15:0]          source_port,
  input  logic                 vlan_present,
  input  logic [11:0]          vlan_id,
  input  logic [47:0]          source_mac,
  input  logic [15:0]          expected_ethertype,
  output lldptlv_pkg::push_t   push
);

  logic [2:0]  parse_phase, parse_phase_next;
  logic [6:0]  tlv_kind, tlv_kind_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [2:0]  seen_flags, seen_flags_next;
  logic [15:0] ttl_value, ttl_value_next;
  logic [15:0] caps_value, caps_value_next;
  logic [15:0] enabled_value, enabled_value_next;
  logic [15:0] saved_port, saved_port_next;
  logic [11:0] saved_vlan, saved_vlan_next;
  logic [47:0] saved_mac, saved_mac_next;

  logic [2:0]  phase_eff;
  logic        bad_eth;
  logic        p_v, t_v;
  logic [1:0]  p_kind;
  logic [2:0]  p_tag;
  logic        p_start;
  logic [7:0]  p_val;
  logic [2:0]  p_status;
  logic [6:0]  hdr_kind;
  logic [8:0]  hdr_len;
  logic [8:0]  left_dec;
  logic        len_bad;
  logic [2:0]  end_status;
  lldptlv_pkg::res_t prim, trunc;

  always_comb begin
    parse_phase_next   = parse_phase;
    tlv_kind_next      = tlv_kind;
    bytes_left_next    = bytes_left;
    held_byte_next     = held_byte;
    seen_flags_next    = seen_flags;
    ttl_value_next     = ttl_value;
    caps_value_next    = caps_value;
    enabled_value_next = enabled_value;
    saved_port_next    = saved_port;
    saved_vlan_next    = saved_vlan;
    saved_mac_next     = saved_mac;
    phase_eff = parse_phase;
    bad_eth   = 1'b0;
    p_v       = 1'b0;
    t_v       = 1'b0;
    p_kind    = lldptlv_pkg::KIND_STRING;
    p_tag     = lldptlv_pkg::TAG_CHASSIS;
    p_start   = 1'b0;
    p_val     = 8'd0;
    p_status  = lldptlv_pkg::ST_OK;

    hdr_kind = held_byte[7:1];
    hdr_len  = {held_byte[0], data_byte} & lldptlv_pkg::LEN_MASK;
    left_dec = bytes_left - 9'd1;
    len_bad  = (((hdr_kind == lldptlv_pkg::TLV_CHASSIS) || (hdr_kind == lldptlv_pkg::TLV_PORT))
                && (hdr_len == 9'd0)) ||
               ((hdr_kind == lldptlv_pkg::TLV_TTL) && (hdr_len != 9'd2)) ||
               ((hdr_kind == lldptlv_pkg::TLV_CAPS) && (hdr_len != 9'd4));
    if (!seen_flags[lldptlv_pkg::FLAG_CHASSIS])   end_status = lldptlv_pkg::ST_NO_CHASSIS;
    else if (!seen_flags[lldptlv_pkg::FLAG_PORT]) end_status = lldptlv_pkg::ST_NO_PORT;
    else if (!seen_flags[lldptlv_pkg::FLAG_TTL])  end_status = lldptlv_pkg::ST_NO_TTL;
    else                                          end_status = lldptlv_pkg::ST_OK;

    if (first_byte) begin
      seen_flags_next = 3'd0;
      tlv_kind_next   = 7'd0;
      bytes_left_next = 9'd0;
      if (ethertype != expected_ethertype) begin
        bad_eth          = 1'b1;
        p_v              = 1'b1;
        p_kind           = lldptlv_pkg::KIND_SUMMARY;
        p_status         = lldptlv_pkg::ST_ETHERTYPE;
        parse_phase_next = lldptlv_pkg::PH_DONE;
      end else begin
        saved_port_next = source_port;
        saved_vlan_next = vlan_present ? vlan_id : 12'd0;
        saved_mac_next  = source_mac;
        phase_eff       = lldptlv_pkg::PH_HDR_HI;
      end
    end

    if (!bad_eth) begin
      case (phase_eff)
        lldptlv_pkg::PH_HDR_HI: begin
          held_byte_next   = data_byte;
          parse_phase_next = lldptlv_pkg::PH_HDR_LO;
        end
        lldptlv_pkg::PH_HDR_LO: begin
          tlv_kind_next   = hdr_kind;
          bytes_left_next = hdr_len;
          if (hdr_kind == lldptlv_pkg::TLV_END) begin
            p_v              = 1'b1;
            p_kind           = lldptlv_pkg::KIND_SUMMARY;
            p_status         = end_status;
            parse_phase_next = lldptlv_pkg::PH_DONE;
          end else if (len_bad) begin
            p_v              = 1'b1;
            p_kind           = lldptlv_pkg::KIND_SUMMARY;
            p_status         = lldptlv_pkg::ST_BAD_LENGTH;
            parse_phase_next = lldptlv_pkg::PH_DONE;
          end else if (hdr_len == 9'd0) begin
            // empty description or name gives a marker
            if ((hdr_kind == lldptlv_pkg::TLV_PORT_DESC) ||
                (hdr_kind == lldptlv_pkg::TLV_SYS_NAME) ||
                (hdr_kind == lldptlv_pkg::TLV_SYS_DESC)) begin
              p_v    = 1'b1;
              p_kind = lldptlv_pkg::KIND_EMPTY;
              p_tag  = lldptlv_pkg::tag_of(hdr_kind);
            end
            parse_phase_next = lldptlv_pkg::PH_HDR_HI;
          end else begin
            parse_phase_next = lldptlv_pkg::PH_BODY_FIRST;
          end
        end
        lldptlv_pkg::PH_BODY_FIRST, lldptlv_pkg::PH_BODY: begin
          bytes_left_next = left_dec;
          case (tlv_kind)
            lldptlv_pkg::TLV_CHASSIS, lldptlv_pkg::TLV_PORT, lldptlv_pkg::TLV_PORT_DESC,
            lldptlv_pkg::TLV_SYS_NAME, lldptlv_pkg::TLV_SYS_DESC: begin
              p_v     = 1'b1;
              p_kind  = lldptlv_pkg::KIND_STRING;
              p_tag   = lldptlv_pkg::tag_of(tlv_kind);
              p_start = (phase_eff == lldptlv_pkg::PH_BODY_FIRST);
              p_val   = data_byte;
              if (left_dec == 9'd0) begin
                if (tlv_kind == lldptlv_pkg::TLV_CHASSIS)
                  seen_flags_next[lldptlv_pkg::FLAG_CHASSIS] = 1'b1;
                else if (tlv_kind == lldptlv_pkg::TLV_PORT)
                  seen_flags_next[lldptlv_pkg::FLAG_PORT] = 1'b1;
              end
            end
            lldptlv_pkg::TLV_TTL: begin
              if (left_dec == 9'd1) begin
                held_byte_next = data_byte;
              end else begin
                ttl_value_next = {held_byte, data_byte};
                seen_flags_next[lldptlv_pkg::FLAG_TTL] = 1'b1;
              end
            end
            lldptlv_pkg::TLV_CAPS: begin
              if ((left_dec == 9'd3) || (left_dec == 9'd1))
                held_byte_next = data_byte;
              else if (left_dec == 9'd2)
                caps_value_next = {held_byte, data_byte};
              else
                enabled_value_next = {held_byte, data_byte};
            end
            default: begin
            end
          endcase
          parse_phase_next = (left_dec == 9'd0) ? lldptlv_pkg::PH_HDR_HI : lldptlv_pkg::PH_BODY;
        end
        default: begin
        end
      endcase

      // frame ends without an End TLV
      if (last_byte && (parse_phase_next != lldptlv_pkg::PH_DONE) &&
          (parse_phase_next != lldptlv_pkg::PH_IDLE)) begin
        t_v              = 1'b1;
        parse_phase_next = lldptlv_pkg::PH_DONE;
      end
    end
  end

  always_comb begin
    prim = '0;
    prim.result_kind = p_kind;
    if (p_kind == lldptlv_pkg::KIND_SUMMARY) begin
      prim.status               = p_status;
      prim.ttl_seconds          = ttl_value_next;
      prim.capabilities         = caps_value_next;
      prim.enabled_capabilities = enabled_value_next;
      prim.echo_port            = saved_port_next;
      prim.echo_vlan            = saved_vlan_next;
      prim.echo_mac             = saved_mac_next;
    end else begin
      prim.field_tag    = p_tag;
      prim.string_start = p_start;
      prim.value_byte   = p_val;
    end

    trunc = '0;
    trunc.result_kind          = lldptlv_pkg::KIND_SUMMARY;
    trunc.status               = lldptlv_pkg::ST_TRUNCATED;
    trunc.ttl_seconds          = ttl_value_next;
    trunc.capabilities         = caps_value_next;
    trunc.enabled_capabilities = enabled_value_next;
    trunc.echo_port            = saved_port_next;
    trunc.echo_vlan            = saved_vlan_next;
    trunc.echo_mac             = saved_mac_next;
    trunc.last_of_run          = 1'b1;

    push.valid0 = accept && (p_v || t_v);
    push.valid1 = accept && p_v && t_v;
    push.res0   = p_v ? prim : trunc;
    push.res0.last_of_run = !(p_v && t_v);
    push.res1   = trunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= lldptlv_pkg::PH_IDLE;
      tlv_kind      <= 7'd0;
      bytes_left    <= 9'd0;
      held_byte     <= 8'd0;
      seen_flags    <= 3'd0;
      ttl_value     <= 16'd0;
      caps_value    <= 16'd0;
      enabled_value <= 16'd0;
      saved_port    <= 16'd0;
      saved_vlan    <= 12'd0;
      saved_mac     <= 48'd0;
    end else if (accept) begin
      parse_phase   <= parse_phase_next;
      tlv_kind      <= tlv_kind_next;
      bytes_left    <= bytes_left_next;
      held_byte     <= held_byte_next;
      seen_flags    <= seen_flags_next;
      ttl_value     <= ttl_value_next;
      caps_value    <= caps_value_next;
      enabled_value <= enabled_value_next;
      saved_port    <= saved_port_next;
      saved_vlan    <= saved_vlan_next;
      saved_mac     <= saved_mac_next;
    end
  end

endmodule

[rtl/lldptlv_outq.sv]
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
// Depends on lldptlv_pkg.
module lldptlv_outq #(
  parameter int DEPTH = lldptlv_pkg::OUTQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  lldptlv_pkg::push_t  push,
  output logic                space2,
  output logic                out_valid,
  input  logic                out_ready,
  output lldptlv_pkg::res_t   out_res
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  lldptlv_pkg::res_t mem [DEPTH];
  logic [PW-1:0] head, head_next, tail, tail1, tail2;
  logic [CW-1:0] count, count_next;
  logic          pop;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    inc = (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  assign tail1     = inc(tail);
  assign tail2     = inc(tail1);
  assign out_valid = (count != '0);
  assign out_res   = mem[head];
  assign pop       = out_valid && out_ready;
  assign space2    = (count <= CW'(DEPTH - 2));
  assign head_next = pop ? inc(head) : head;

  always_comb begin
    count_next = count;
    if (push.valid0) count_next = count_next + CW'(1);
    if (push.valid1) count_next = count_next + CW'(1);
    if (pop)         count_next = count_next - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      if (push.valid1)      tail <= tail2;
      else if (push.valid0) tail <= tail1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) mem[tail]  <= push.res0;
    if (push.valid1) mem[tail1] <= push.res1;
  end

endmodule

[rtl/lldp_tlv_stream_parser.sv]
`timescale 1ns / 1ps
// LLDP TLV stream parser, top level: ports, ethertype register, parse step and result queue.
// Depends on lldptlv_pkg, lldptlv_parse and lldptlv_outq.
//
// Takes one LLDP payload byte per word, one word per clock while s_tready is
// high. Each accepted word updates the parser state in the same cycle and places
// zero, one or two result words into a small output queue (two only when a frame
// ends without an End TLV behind a string byte or an empty-string marker). s_tready
// is high while the queue has room for two results, so with a taking sink the block
// runs at one input word per cycle; results reach m_* from the queue registers.
// Write cfg_wr_en/cfg_wr_data only while no frame is in flight.
module lldp_tlv_stream_parser #(
  parameter int OUTQ_DEPTH = lldptlv_pkg::OUTQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,  // expected_ethertype
  input  logic         s_tvalid,
  output logic         s_tready,
  // data_byte[7:0], ethertype[23:8], source_port[39:24], vlan_present[40],
  // vlan_id[52:41], source_mac[100:53], zero[103:101]
  input  logic [103:0] s_tdata,
  input  logic         s_tlast,      // last_byte
  input  logic         s_tuser,      // first_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // field_tag[2:0], string_start[3], value_byte[11:4], status[14:12],
  // ttl_seconds[30:15], capabilities[46:31], enabled_capabilities[62:47],
  // echo_port[78:63], echo_vlan[90:79], echo_mac[138:91], zero[143:139]
  output logic [143:0] m_tdata,
  output logic         m_tlast,      // last_of_run
  output logic [1:0]   m_tuser       // result_kind
);

  logic [15:0]        expected_ethertype;
  logic               accept;
  lldptlv_pkg::push_t push;
  lldptlv_pkg::res_t  head_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_ethertype <= lldptlv_pkg::LLDP_ETHERTYPE;
    end else if (cfg_wr_en) begin
      expected_ethertype <= cfg_wr_data;
    end
  end

  assign accept = s_tvalid && s_tready;

  lldptlv_parse u_parse (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .data_byte          (s_tdata[7:0]),
    .first_byte         (s_tuser),
    .last_byte          (s_tlast),
    .ethertype          (s_tdata[23:8]),
    .source_port        (s_tdata[39:24]),
    .vlan_present       (s_tdata[40]),
    .vlan_id            (s_tdata[52:41]),
    .source_mac         (s_tdata[100:53]),
    .expected_ethertype (expected_ethertype),
    .push               (push)
  );

  lldptlv_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space2    (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (head_res)
  );

  assign m_tdata = {5'd0, head_res.echo_mac, head_res.echo_vlan, head_res.echo_port,
                    head_res.enabled_capabilities, head_res.capabilities,
                    head_res.ttl_seconds, head_res.status, head_res.value_byte,
                    head_res.string_start, head_res.field_tag};
  assign m_tlast = head_res.last_of_run;
  assign m_tuser = head_res.result_kind;

endmodule
